// ----- hdl/iirt_pkg.sv -----
// Shared types and constants for the transposed direct form II IIR filter.
`default_nettype none
package iirt_pkg;

   localparam int ORDER     = 4;
   localparam int FRAC_BITS = 26;
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int INDEX_W   = 3;
   localparam int DELAY_W   = 56;
   localparam int ACC_W     = DELAY_W + 2;

   // tap counter and coefficient slot widths
   localparam int KW = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int FW = $clog2(ORDER + 1);

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = 2;
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_AW    = 1;

   localparam logic signed [COEF_W-1:0]   COEF_ONE   = COEF_W'(2 ** FRAC_BITS);
   localparam logic signed [ACC_W-1:0]    ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [DELAY_W-1:0]  DELAY_MAX  = {1'b0, {(DELAY_W - 1){1'b1}}};
   localparam logic signed [DELAY_W-1:0]  DELAY_MIN  = {1'b1, {(DELAY_W - 1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX    = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN    = {1'b1, {(SAMPLE_W - 1){1'b0}}};

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_FEED   = 2'd1,
      REQ_BACK   = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      OP_SAMPLE,
      OP_FEED,
      OP_BACK,
      OP_CLEAR,
      OP_SKIP
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [FW-1:0]              slot;
      logic signed [COEF_W-1:0]   coef;
      logic signed [SAMPLE_W-1:0] sample;
   } cmd_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_Y,
      ST_FX,
      ST_AY
   } eng_state_type;

endpackage
`default_nettype wire

// ----- hdl/iirt_front.sv -----
// Input side: takes request words, classifies them and queues them for the engine.
`default_nettype none
module iirt_front
   import iirt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [1:0]                 req_type,
   input  wire logic [INDEX_W-1:0]         req_coef_index,
   input  wire logic signed [COEF_W-1:0]   req_coef_value,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                            cmd_valid,
   output cmd_type                         cmd,
   input  wire logic                       cmd_pop
);

   cmd_type              queue_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff, count_in;
   logic                 accept;
   cmd_type              decoded;

   assign full      = (count_ff == (CMDQ_AW + 1)'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign accept    = push && !full;
   assign cmd       = queue_ff[rd_ptr_ff];

   // classify; out-of-range coefficient writes become skips
   always_comb begin
      decoded.op     = OP_SKIP;
      decoded.slot   = FW'(req_coef_index);
      decoded.coef   = req_coef_value;
      decoded.sample = req_sample_in;
      case (req_kind_type'(req_type))
         REQ_SAMPLE: decoded.op = OP_SAMPLE;
         REQ_FEED: begin
            if (32'(req_coef_index) <= ORDER) decoded.op = OP_FEED;
         end
         REQ_BACK: begin
            decoded.slot = FW'(req_coef_index - INDEX_W'(1));
            if (req_coef_index != '0 && 32'(req_coef_index) <= ORDER) decoded.op = OP_BACK;
         end
         REQ_CLEAR: decoded.op = OP_CLEAR;
         default: decoded.op = OP_SKIP;
      endcase
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + CMDQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + CMDQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !cmd_pop) count_in = count_ff + (CMDQ_AW + 1)'(1);
      if (!accept && cmd_pop) count_in = count_ff - (CMDQ_AW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) queue_ff[wr_ptr_ff] <= decoded;
   end

endmodule
`default_nettype wire

// ----- hdl/iirt_engine.sv -----
// Filter engine: coefficient and delay storage, one shared multiplier stepped over the taps.
`default_nettype none
module iirt_engine
   import iirt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_push,
   output rsp_type      rsp_word,
   input  wire logic    rsp_full
);

   eng_state_type               state_ff, state_in;
   logic [KW-1:0]               k_ff;
   logic signed [COEF_W-1:0]    feed_ff [ORDER + 1];
   logic signed [COEF_W-1:0]    back_ff [ORDER];
   logic signed [DELAY_W-1:0]   delay_ff [ORDER];
   logic signed [DELAY_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]     t_ff;
   logic signed [SAMPLE_W-1:0]  x_ff, y_ff;

   logic signed [COEF_W-1:0]    mul_coef;
   logic signed [SAMPLE_W-1:0]  mul_opnd;
   logic signed [DELAY_W-1:0]   mul_p;
   logic [KW:0]                 k_inc;
   logic [FW:0]                 f2;
   logic                        last;
   logic signed [DELAY_W-1:0]   dnext;
   logic signed [ACC_W-1:0]     acc, diff;
   logic [ACC_W-FRAC_BITS-SAMPLE_W:0] acc_top;
   logic                        y_over;
   logic signed [SAMPLE_W-1:0]  y_sat;
   logic                        d_over;
   logic signed [DELAY_W-1:0]   d_sat;

   assign k_inc = (KW + 1)'(k_ff) + (KW + 1)'(1);
   assign f2    = (FW + 1)'(k_ff) + (FW + 1)'(2);
   assign last  = (32'(k_inc) == ORDER);
   assign dnext = last ? '0 : delay_ff[k_inc[KW-1:0]];
   assign mul_p = mul_coef * mul_opnd;

   // output rounding and saturation
   assign acc     = ACC_W'(prod_ff) + ACC_W'(delay_ff[0]) + ROUND_HALF;
   assign acc_top = acc[ACC_W-1:FRAC_BITS+SAMPLE_W-1];
   assign y_over  = !((&acc_top) || !(|acc_top));
   assign y_sat   = y_over ? (acc[ACC_W-1] ? OUT_MIN : OUT_MAX)
                           : acc[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
   assign rsp_word.sample  = y_sat;
   assign rsp_word.clipped = y_over;

   // new delay term, saturated to its register width
   assign diff  = t_ff - ACC_W'(prod_ff);
   assign d_over = !((&diff[ACC_W-1:DELAY_W-1]) || !(|diff[ACC_W-1:DELAY_W-1]));
   assign d_sat  = d_over ? (diff[ACC_W-1] ? DELAY_MIN : DELAY_MAX) : diff[DELAY_W-1:0];

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      mul_coef = feed_ff[0];
      mul_opnd = cmd.sample;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_SAMPLE) state_in = ST_Y;
            end
         end
         ST_Y: begin
            mul_coef = feed_ff[1];
            mul_opnd = x_ff;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_FX;
            end
         end
         ST_FX: begin
            mul_coef = back_ff[k_ff];
            mul_opnd = y_ff;
            state_in = ST_AY;
         end
         ST_AY: begin
            mul_coef = last ? feed_ff[0] : feed_ff[f2[FW-1:0]];
            mul_opnd = x_ff;
            state_in = last ? ST_IDLE : ST_FX;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         for (int i = 0; i <= ORDER; i++) feed_ff[i] <= (i == 0) ? COEF_ONE : '0;
         for (int i = 0; i < ORDER; i++) begin
            back_ff[i]  <= '0;
            delay_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               k_ff <= '0;
               if (cmd_pop) begin
                  case (cmd.op)
                     OP_FEED: feed_ff[cmd.slot] <= cmd.coef;
                     OP_BACK: back_ff[cmd.slot[KW-1:0]] <= cmd.coef;
                     OP_CLEAR: begin
                        for (int i = 0; i < ORDER; i++) delay_ff[i] <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_AY: begin
               delay_ff[k_ff] <= d_sat;
               if (!last) k_ff <= k_inc[KW-1:0];
            end
            default: ;
         endcase
      end
   end

   // datapath registers; hold b0*x and y while the result queue is full
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            prod_ff <= mul_p;
            x_ff    <= cmd.sample;
         end
         ST_Y: begin
            if (!rsp_full) begin
               prod_ff <= mul_p;
               y_ff    <= y_sat;
            end
         end
         ST_FX: begin
            prod_ff <= mul_p;
            t_ff    <= ACC_W'(prod_ff) + ACC_W'(dnext);
         end
         ST_AY: prod_ff <= mul_p;
         default: ;
      endcase
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full) else $error("result pushed into a full queue");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE)) else $error("command taken while busy");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.op == OP_CLEAR) |=> (delay_ff[0] == '0))
      else $error("clear left delay state");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      32'(k_ff) < ORDER) else $error("tap counter out of range");

   a_push_then_taps: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (state_ff == ST_FX && k_ff == '0))
      else $error("delay update did not follow output");

endmodule
`default_nettype wire

// ----- hdl/iirt_rsp_queue.sv -----
// Two-entry result queue between the engine and the result port.
`default_nettype none
module iirt_rsp_queue
   import iirt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_push,
   input  wire rsp_type rsp_word,
   output logic         rsp_full,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      head
);

   rsp_type             queue_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [RSPQ_AW:0]    count_ff, count_in;
   logic                take;

   assign rsp_full = (count_ff == (RSPQ_AW + 1)'(RSPQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign take     = pop && !empty;
   assign head     = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (rsp_push && !take) count_in = count_ff + (RSPQ_AW + 1)'(1);
      if (!rsp_push && take) count_in = count_ff - (RSPQ_AW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (rsp_push) wr_ptr_ff <= wr_ptr_ff + RSPQ_AW'(1);
         if (take) rd_ptr_ff <= rd_ptr_ff + RSPQ_AW'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) queue_ff[wr_ptr_ff] <= rsp_word;
   end

endmodule
`default_nettype wire

// ----- hdl/iir_transposed_direct_form2_core.sv -----
// Top level of the transposed direct form II IIR filter core.
// Usage:
//  - Request side is a queue: drive a word on req_* with push high; it is taken at a clock
//    edge where full is low. req_type selects sample, feedforward write, feedback write
//    or delay clear; coefficient writes with an index out of range are dropped.
//  - Result side is a queue: while empty is low, rsp_sample_out/rsp_clipped hold the
//    oldest result; pop high at an edge where empty is low takes it. Only samples give
//    results, one each, in request order.
//  - A four-word command queue decouples the request port from the engine; a two-word
//    result queue decouples the engine from the result port.
//  - A sample taken into idle queues passes the command queue, the engine's ST_IDLE and ST_Y
//    states and then the result queue before its result shows. The engine finishes each sample
//    before it takes the next command; the single shared multiplier does b0*x, then b(k+1)*x and a(k+1)*y per tap.
//    Coefficient writes, clears and dropped writes are handled in the engine's idle state.
//  - When the receiver stalls, the engine holds the finished sample until the result
//    queue has room; requests keep queuing until the command queue fills.
//  - Reset (synchronous, active high) empties both queues, sets b0 to 1.0 and all other
//    coefficients and the delay state to zero.
`default_nettype none
module iir_transposed_direct_form2_core
   import iirt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [1:0]                 req_type,
   input  wire logic [INDEX_W-1:0]         req_coef_index,
   input  wire logic signed [COEF_W-1:0]   req_coef_value,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                            empty,
   input  wire logic                       pop,
   output logic signed [SAMPLE_W-1:0]      rsp_sample_out,
   output logic                            rsp_clipped
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    rsp_push;
   logic    rsp_full;
   rsp_type rsp_word;
   rsp_type rsp_head;

   // front: classify and queue request words
   iirt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_sample_in  (req_sample_in),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // back: run the filter recursion one tap step at a time
   iirt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word),
      .rsp_full  (rsp_full)
   );

   // hold finished results until the receiver pops them
   iirt_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_word (rsp_word),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .head     (rsp_head)
   );

   assign rsp_sample_out = rsp_head.sample;
   assign rsp_clipped    = rsp_head.clipped;

endmodule
`default_nettype wire
